// ===== src/smf_pkg.sv =====
// smf_pkg: shared types and fixed payload widths for the sliding median filter.
// Used by the channel interfaces, the sorter cells and the top level.
`default_nettype none

package smf_pkg;

   // Payload widths of the request and response beats
   localparam int SAMPLE_W = 24;
   localparam int MEDIAN_W = 24;

   // Per-cell flags handed to the neighboring cells each cycle
   typedef struct packed {
      logic le;      // cell value is less than or equal to the incoming sample
      logic shift;   // cell sits at or after the evicted entry
   } cell_link_type;

endpackage : smf_pkg

`default_nettype wire

// ===== src/smf_if.sv =====
// smf_if: valid/ready channel interfaces for request and response beats.
// Depends on smf_pkg for the payload widths.
`default_nettype none

interface smf_req_if;
   logic                          valid;
   logic                          ready;
   logic [smf_pkg::SAMPLE_W-1:0]  sample;
   logic                          frame_start;

   modport source (output valid, output sample, output frame_start, input ready);
   modport sink   (input valid, input sample, input frame_start, output ready);
endinterface : smf_req_if

interface smf_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [smf_pkg::MEDIAN_W-1:0]  median;

   modport source (output valid, output median, input ready);
   modport sink   (input valid, input median, output ready);
endinterface : smf_rsp_if

`default_nettype wire

// ===== src/smf_cell.sv =====
// smf_cell: one slot of the sorted window chain; holds a value and its age.
// Depends on smf_pkg for the neighbor link struct.
`default_nettype none

module smf_cell #(
   parameter int WINDOW   = 200,
   parameter int VAL_BITS = 24,
   parameter int AGE_BITS = 8,
   parameter int INDEX    = 0
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire logic                  clear,
   input  wire logic [VAL_BITS-1:0]   smp,
   input  wire logic [VAL_BITS-1:0]   v_old,
   input  wire logic [VAL_BITS-1:0]   prev_val,
   input  wire logic [AGE_BITS-1:0]   prev_age,
   input  wire smf_pkg::cell_link_type prev_link,
   input  wire logic [VAL_BITS-1:0]   next_val,
   input  wire logic [AGE_BITS-1:0]   next_age,
   input  wire smf_pkg::cell_link_type next_link,
   output logic [VAL_BITS-1:0]        val_q,
   output logic [VAL_BITS-1:0]        eff_val,
   output logic [AGE_BITS-1:0]        eff_age,
   output smf_pkg::cell_link_type     link
);
   import smf_pkg::*;

   localparam logic [AGE_BITS-1:0] AGE_MAX  = AGE_BITS'(WINDOW - 1);
   localparam logic [AGE_BITS-1:0] INIT_AGE = AGE_BITS'(WINDOW - 1 - INDEX);
   localparam bit                  IS_FIRST = (INDEX == 0);
   localparam bit                  IS_LAST  = (INDEX == WINDOW - 1);

   logic [VAL_BITS-1:0] val_ff, val_in;
   logic [AGE_BITS-1:0] age_ff, age_in;
   logic                evict;
   logic                after_evict;
   logic                own_r_le;
   logic                prev_r_le;
   logic [VAL_BITS-1:0] sel_val;
   logic [AGE_BITS-1:0] sel_age;

   // Frame start makes the window look freshly reset for this beat
   always_comb begin
      eff_val = clear ? '0 : val_ff;
      eff_age = clear ? INIT_AGE : age_ff;
   end

   // Classify this slot against the evicted entry and the new sample
   always_comb begin
      evict       = (eff_age == AGE_MAX);
      after_evict = (eff_val > v_old) || ((eff_val == v_old) && !evict);
      link.shift  = after_evict || evict;
      link.le     = (eff_val <= smp);
   end

   // Pick the new content: keep or pull from a neighbor, or take the sample
   always_comb begin
      own_r_le  = link.shift ? (next_link.le & !IS_LAST) : link.le;
      prev_r_le = IS_FIRST | (prev_link.shift ? link.le : prev_link.le);
      if (own_r_le) begin
         sel_val = link.shift ? next_val : eff_val;
         sel_age = link.shift ? next_age : eff_age;
      end else begin
         sel_val = prev_link.shift ? eff_val : prev_val;
         sel_age = prev_link.shift ? eff_age : prev_age;
      end
      if (!own_r_le && prev_r_le) begin
         val_in = smp;
         age_in = '0;
      end else begin
         val_in = sel_val;
         age_in = sel_age + AGE_BITS'(1);
      end
   end

   // Advance on each accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff <= '0;
         age_ff <= INIT_AGE;
      end else if (accept) begin
         val_ff <= val_in;
         age_ff <= age_in;
      end
   end

   assign val_q = val_ff;

endmodule : smf_cell

`default_nettype wire

// ===== src/smf_oldest.sv =====
// smf_oldest: circular sample store that prefetches the entry due for eviction.
// Instantiates no submodules but imports smf_pkg; the fill count stands in for clearing the store.
`default_nettype none

module smf_oldest #(
   parameter int WINDOW   = 200,
   parameter int VAL_BITS = 24
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                accept,
   input  wire logic                clear,
   input  wire logic [VAL_BITS-1:0] smp,
   output logic [VAL_BITS-1:0]      v_old
);
   import smf_pkg::*;

   localparam int PTR_BITS  = $clog2(WINDOW);
   localparam int FILL_BITS = $clog2(WINDOW + 1);
   localparam logic [PTR_BITS-1:0]  PTR_LAST = PTR_BITS'(WINDOW - 1);
   localparam logic [FILL_BITS-1:0] FILL_MAX = FILL_BITS'(WINDOW);

   logic [VAL_BITS-1:0]  store_mem [WINDOW];
   logic [PTR_BITS-1:0]  wr_ff, wr_in, wr_eff;
   logic [FILL_BITS-1:0] fill_ff, fill_in, fill_eff;
   logic [VAL_BITS-1:0]  old_ff;
   logic                 old_ok_ff, old_ok_in;

   // Step the write position and the fill count since frame start
   always_comb begin
      wr_eff    = clear ? '0 : wr_ff;
      fill_eff  = clear ? '0 : fill_ff;
      wr_in     = (wr_eff == PTR_LAST) ? '0 : wr_eff + PTR_BITS'(1);
      fill_in   = (fill_eff == FILL_MAX) ? FILL_MAX : fill_eff + FILL_BITS'(1);
      old_ok_in = (FILL_BITS'(wr_in) < fill_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff     <= '0;
         fill_ff   <= '0;
         old_ok_ff <= 1'b0;
      end else if (accept) begin
         wr_ff     <= wr_in;
         fill_ff   <= fill_in;
         old_ok_ff <= old_ok_in;
      end
   end

   // Write the new sample, fetch the next one to be evicted
   always_ff @(posedge clock) begin
      if (accept) begin
         store_mem[wr_eff] <= smp;
         old_ff            <= store_mem[wr_in];
      end
   end

   // Unwritten positions since frame start hold zero
   assign v_old = (clear || !old_ok_ff) ? '0 : old_ff;

endmodule : smf_oldest

`default_nettype wire

// ===== src/sliding_median_filter.sv =====
// sliding_median_filter: running median over the last WINDOW samples.
// The median for a beat is on rsp in the cycle after the request beat is taken.
// Throughput: one beat per cycle while rsp_ch.ready stays high; set by the single
// output register, and the sorted cell chain updates once per beat.
// Reset (synchronous): window reads as all zeros, write position at zero, no response.
// Depends on smf_pkg, smf_if, smf_cell and smf_oldest.
`default_nettype none

module sliding_median_filter #(
   parameter int WINDOW      = 200,
   parameter int SAMPLE_BITS = 24
) (
   input  wire logic clock,
   input  wire logic reset,
   smf_req_if.sink   req_ch,
   smf_rsp_if.source rsp_ch
);
   import smf_pkg::*;

   localparam int VAL_BITS = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
   localparam int AGE_BITS = $clog2(WINDOW);
   localparam int RANK     = WINDOW / 2;
   localparam logic [AGE_BITS-1:0] AGE_MAX = AGE_BITS'(WINDOW - 1);

   logic                rsp_valid_ff, rsp_valid_in;
   logic                accept;
   logic                clear;
   logic [VAL_BITS-1:0] smp;
   logic [VAL_BITS-1:0] v_old;

   logic [VAL_BITS-1:0] val_q    [WINDOW];
   logic [VAL_BITS-1:0] eff_val  [WINDOW];
   logic [AGE_BITS-1:0] eff_age  [WINDOW];
   cell_link_type       link     [WINDOW];
   logic [VAL_BITS-1:0] prev_val [WINDOW];
   logic [AGE_BITS-1:0] prev_age [WINDOW];
   cell_link_type       prev_link[WINDOW];
   logic [VAL_BITS-1:0] next_val [WINDOW];
   logic [AGE_BITS-1:0] next_age [WINDOW];
   cell_link_type       next_link[WINDOW];
   logic [WINDOW-1:0]   oldest_vec;

   // Take a beat whenever the output slot is free or being emptied
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign clear        = req_ch.frame_start;
   assign smp          = req_ch.sample[VAL_BITS-1:0];

   smf_oldest #(
      .WINDOW   (WINDOW),
      .VAL_BITS (VAL_BITS)
   ) u_oldest (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .clear  (clear),
      .smp    (smp),
      .v_old  (v_old)
   );

   // Sorted chain of cells, each wired to its neighbors; the end cells see zeros past the ends
   for (genvar i = 0; i < WINDOW; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign prev_val[i]  = '0;
         assign prev_age[i]  = '0;
         assign prev_link[i] = '0;
      end else begin : g_mid_prev
         assign prev_val[i]  = eff_val[i-1];
         assign prev_age[i]  = eff_age[i-1];
         assign prev_link[i] = link[i-1];
      end
      if (i == WINDOW - 1) begin : g_tail
         assign next_val[i]  = '0;
         assign next_age[i]  = '0;
         assign next_link[i] = '0;
      end else begin : g_mid_next
         assign next_val[i]  = eff_val[i+1];
         assign next_age[i]  = eff_age[i+1];
         assign next_link[i] = link[i+1];
      end
      assign oldest_vec[i] = (eff_age[i] == AGE_MAX);

      smf_cell #(
         .WINDOW   (WINDOW),
         .VAL_BITS (VAL_BITS),
         .AGE_BITS (AGE_BITS),
         .INDEX    (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .accept    (accept),
         .clear     (clear),
         .smp       (smp),
         .v_old     (v_old),
         .prev_val  (prev_val[i]),
         .prev_age  (prev_age[i]),
         .prev_link (prev_link[i]),
         .next_val  (next_val[i]),
         .next_age  (next_age[i]),
         .next_link (next_link[i]),
         .val_q     (val_q[i]),
         .eff_val   (eff_val[i]),
         .eff_age   (eff_age[i]),
         .link      (link[i])
      );
   end

   // Hold the response until taken; the median cell holds the value meanwhile
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.median = MEDIAN_W'(val_q[RANK]);

   // Every taken beat yields a response on the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("response missing after accepted beat");

   // Exactly one cell is due for eviction
   a_one_oldest: assert property (@(posedge clock) disable iff (reset)
      $onehot(oldest_vec))
      else $error("eviction candidate not unique");

   // Chain stays sorted around the median slot
   a_sorted: assert property (@(posedge clock) disable iff (reset)
      val_q[RANK-1] <= val_q[RANK])
      else $error("cell chain out of order at median");

endmodule : sliding_median_filter

`default_nettype wire

// ===== tb/sv/tb_sliding_median_filter.sv =====
`timescale 1ns / 100ps
// tb_sliding_median_filter: self-checking bench for the running median over the sample window.
// Needs smf_pkg, smf_if and the sliding_median_filter top level with its cells.

// Track the window contents, keep a sorted copy and queue the median due for each beat
class median_tracker #(int DEPTH = 200, int BITS = 24);
   bit [smf_pkg::SAMPLE_W-1:0] history [DEPTH];
   bit [smf_pkg::SAMPLE_W-1:0] ranked [$];
   int unsigned                oldest;
   bit [smf_pkg::MEDIAN_W-1:0] pending [$];
   int unsigned                errors;

   function new();
      clear_window();
      errors = 0;
   endfunction

   // Zero every slot and return the write position to the start
   function void clear_window();
      ranked.delete();
      for (int i = 0; i < DEPTH; i++) begin
         history[i] = '0;
         ranked.push_back('0);
      end
      oldest = 0;
   endfunction

   // Insert one accepted request beat and queue the median it produces
   function void note_sample(input logic [smf_pkg::SAMPLE_W-1:0] sample,
                             input logic frame_start);
      bit [smf_pkg::SAMPLE_W-1:0] kept;
      bit [smf_pkg::SAMPLE_W-1:0] evicted;
      int                         slot;
      kept = sample & ~({smf_pkg::SAMPLE_W{1'b1}} << BITS);
      if (frame_start === 1'b1)
         clear_window();
      evicted = history[oldest];
      history[oldest] = kept;
      oldest = (oldest + 1 == DEPTH) ? 0 : oldest + 1;
      // drop one copy of the evicted value, then place the new one in order
      slot = 0;
      while (ranked[slot] != evicted)
         slot++;
      ranked.delete(slot);
      slot = 0;
      while (slot < ranked.size() && ranked[slot] <= kept)
         slot++;
      ranked.insert(slot, kept);
      pending.push_back(ranked[DEPTH / 2]);
   endfunction

   // Compare one response beat against the oldest queued median
   function void check_median(input logic [smf_pkg::MEDIAN_W-1:0] median);
      bit [smf_pkg::MEDIAN_W-1:0] want;
      if (pending.size() == 0) begin
         $error("median: response beat with nothing pending, actual %06h", median);
         errors++;
         return;
      end
      want = pending.pop_front();
      if (median !== want) begin
         $error("median: expected %06h, actual %06h", want, median);
         errors++;
      end
   endfunction
endclass

module tb_sliding_median_filter;
   import smf_pkg::*;

   localparam int WINDOW       = 200;
   localparam int SAMPLE_BITS  = 24;
   localparam int ITEM_TARGET  = 1000;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 10;

   typedef enum int {SPREAD, CLUSTER, EXTREME} level_mode_type;

   logic clock;
   logic reset;

   smf_req_if req_ch ();
   smf_rsp_if rsp_ch ();

   median_tracker #(WINDOW, SAMPLE_BITS) tracker;

   int unsigned cycle_count = 0;
   int unsigned beats_sent  = 0;
   bit          steady      = 1'b0;

   sliding_median_filter #(
      .WINDOW      (WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one; none while steady
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (steady)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 65)
         return 0;
      if (r < 95)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Count cycles, watch both channels and stop a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            tracker.note_sample(req_ch.sample, req_ch.frame_start);
         if (rsp_ch.valid && rsp_ch.ready)
            tracker.check_median(rsp_ch.median);
      end
   end

   // Stall the response side at random
   initial begin
      int unsigned run;
      int unsigned stall;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         run = steady ? 50 : $urandom_range(1, 12);
         rsp_ch.ready <= 1'b1;
         repeat (run) @(posedge clock);
         stall = pick_gap();
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   // Offer one request beat after a random gap and hold it until taken
   task automatic send_beat(input logic [SAMPLE_W-1:0] sample, input logic frame_start);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.sample      <= sample;
      req_ch.frame_start <= frame_start;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      beats_sent++;
   endtask

   // Wait until every queued median has come back
   task automatic wait_drained();
      @(posedge clock);
      while (tracker.pending.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      int unsigned      frame_len;
      level_mode_type   mode;
      logic [SAMPLE_W-1:0] base;
      logic [SAMPLE_W-1:0] level;
      bit               paused;
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.sample      <= '0;
      req_ch.frame_start <= 1'b0;
      tracker = new();
      paused  = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, duplicates, frame starts mid-stream and back to back
      send_beat(24'hFFFFFF, 1'b1);
      send_beat(24'h000000, 1'b0);
      send_beat(24'hFFFFFF, 1'b0);
      send_beat(24'h000001, 1'b0);
      send_beat(24'h800000, 1'b0);
      send_beat(24'h7FFFFF, 1'b0);
      repeat (3) send_beat(24'hAAAAAA, 1'b0);
      repeat (2) send_beat(24'h555555, 1'b0);
      send_beat(24'h123456, 1'b1);
      repeat (4) send_beat(24'hFFFFFF, 1'b0);
      send_beat(24'h000000, 1'b1);
      send_beat(24'hFFFFFE, 1'b1);
      send_beat(24'h000000, 1'b0);
      send_beat(24'hFEDCBA, 1'b0);
      send_beat(24'h0F0F0F, 1'b0);

      // Random: mostly frames long enough to fill the window, some cut short
      while (beats_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 99) < 80)
            frame_len = $urandom_range(150, 420);
         else
            frame_len = $urandom_range(1, 30);
         mode   = level_mode_type'($urandom_range(0, 2));
         base   = SAMPLE_W'($urandom);
         steady = ($urandom_range(0, 4) == 0);
         for (int k = 0; k < frame_len && beats_sent < ITEM_TARGET; k++) begin
            case (mode)
               SPREAD:  level = SAMPLE_W'($urandom);
               CLUSTER: level = SAMPLE_W'(base + $urandom_range(0, 7));
               default: begin
                  case ($urandom_range(0, 2))
                     0:       level = '0;
                     1:       level = '1;
                     default: level = SAMPLE_W'($urandom);
                  endcase
               end
            endcase
            send_beat(level, (k == 0) || ($urandom_range(0, 299) == 0));
            // hold off once mid-run until the pipe is empty
            if (!paused && beats_sent >= ITEM_TARGET / 2) begin
               req_ch.valid <= 1'b0;
               wait_drained();
               paused = 1'b1;
            end
         end
      end
      steady = 1'b0;
      req_ch.valid <= 1'b0;

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
src/smf_pkg.sv
src/smf_if.sv
src/smf_cell.sv
src/smf_oldest.sv
src/sliding_median_filter.sv
tb/sv/tb_sliding_median_filter.sv
